// ----- design/bwts_pkg.sv -----
// ----------------------------------------------------------------------------
// bwts_pkg: shared types and constants of the bilinear texture sampler
// Texel layout, action codes, pipeline control word and size helpers.
// ----------------------------------------------------------------------------
package bwts_pkg;

  localparam int unsigned DIM_W     = 9;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned TEXELS    = 65536;
  localparam int unsigned MAX_DIM   = 256;
  localparam int unsigned WGT_W     = 2 * FRAC_BITS + 1;
  localparam int unsigned PROD_W    = WGT_W + 8;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned NTAPS     = 4;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_SAMPLE = 2'd2
  } action_e;

  typedef logic [31:0]          texel_t;
  typedef logic [WGT_W-1:0]     weight_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [DIM_W-1:0]     dim_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] act;
    logic       inb;
  } ctl_t;

  // A size of zero acts as one, anything above the largest size as that size.
  function automatic dim_t eff_dim(input dim_t r);
    dim_t res;
    res = r;
    if (r == '0) begin
      res = dim_t'(1);
    end else if (r > dim_t'(MAX_DIM)) begin
      res = dim_t'(MAX_DIM);
    end
    return res;
  endfunction

endpackage

// ----- design/bwts_ram.sv -----
// ----------------------------------------------------------------------------
// bwts_ram: texel memory copy
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bwts_ram (
  input  logic             clk_i,
  input  logic             we_i,
  input  bwts_pkg::addr_t  waddr_i,
  input  bwts_pkg::texel_t wdata_i,
  input  bwts_pkg::addr_t  raddr_i,
  output bwts_pkg::texel_t rdata_o
);
  import bwts_pkg::*;

  texel_t mem [TEXELS];
  texel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bwts_addr.sv -----
// ----------------------------------------------------------------------------
// bwts_addr: address and weight generation
// Two stages: scaled coordinates, then neighbor addresses and bilinear weights.
// ----------------------------------------------------------------------------
module bwts_addr (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  bwts_pkg::dim_t                              w_i,
  input  bwts_pkg::dim_t                              h_i,
  input  bwts_pkg::ctl_t                              ctl_i,
  input  logic [7:0]                                  x_i,
  input  logic [7:0]                                  y_i,
  input  logic [bwts_pkg::COORD_W-1:0]                u_i,
  input  logic [bwts_pkg::COORD_W-1:0]                v_i,
  input  bwts_pkg::texel_t                            wdata_i,
  output bwts_pkg::ctl_t                              ctl_o,
  output bwts_pkg::addr_t                             rw_addr_o,
  output bwts_pkg::texel_t                            wdata_o,
  output bwts_pkg::addr_t [bwts_pkg::NTAPS-1:0]       tap_addr_o,
  output logic [bwts_pkg::NTAPS-1:0]                  tap_zero_o,
  output bwts_pkg::weight_t [bwts_pkg::NTAPS-1:0]     wgt_o
);
  import bwts_pkg::*;

  localparam int unsigned PU_W = FRAC_BITS + DIM_W;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Stage 1
  ctl_t                ctl1_q;
  logic [PU_W-1:0]     pu_d, pu_q, pv_d, pv_q;
  logic [16:0]         addr1_d, addr1_q;
  logic                inb_d;
  texel_t              wdata1_q;
  logic [COORD_W-1:0]  absu, absv;

  // Stage 2
  ctl_t                ctl2_q;
  addr_t               rw_addr2_q;
  texel_t              wdata2_q;
  addr_t   [NTAPS-1:0] tap_d, tap_q;
  logic    [NTAPS-1:0] zero_d, zero_q;
  weight_t [NTAPS-1:0] wgt_d, wgt_q;

  logic [7:0]           u1, v1, u2, v2;
  logic [8:0]           u1p, v1p, u2w, v2w;
  logic [16:0]          rowa, rowb;
  logic [16:0]          a [NTAPS];
  logic [FRAC_BITS-1:0] fu, fv;
  logic [FRAC_BITS:0]   omfu, omfv;

  always_comb begin
    absu = u_i[COORD_W-1] ? (~u_i + COORD_W'(1)) : u_i;
    absv = v_i[COORD_W-1] ? (~v_i + COORD_W'(1)) : v_i;
    // The integer part of |c| times the size is a multiple of the size, so
    // only the fraction times the size matters for the wrapped position.
    pu_d = PU_W'(absu[FRAC_BITS-1:0]) * PU_W'(w_i);
    pv_d = PU_W'(absv[FRAC_BITS-1:0]) * PU_W'(h_i);
    addr1_d = 17'(y_i) * 17'(w_i) + 17'(x_i);
    inb_d = ({1'b0, x_i} < w_i) && ({1'b0, y_i} < h_i) && (32'(addr1_d) < TEXELS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else begin
      ctl1_q <= '{valid: ctl_i.valid, act: ctl_i.act, inb: inb_d};
    end
  end

  always_ff @(posedge clk_i) begin
    pu_q     <= pu_d;
    pv_q     <= pv_d;
    addr1_q  <= addr1_d;
    wdata1_q <= wdata_i;
  end

  always_comb begin
    u1   = pu_q[FRAC_BITS +: 8];
    v1   = pv_q[FRAC_BITS +: 8];
    u1p  = {1'b0, u1} + 9'd1;
    v1p  = {1'b0, v1} + 9'd1;
    u2w  = (u1p == w_i) ? 9'd0 : u1p;
    v2w  = (v1p == h_i) ? 9'd0 : v1p;
    u2   = u2w[7:0];
    v2   = v2w[7:0];
    rowa = 17'(v1) * 17'(w_i);
    rowb = 17'(v2) * 17'(w_i);
    a[0] = rowa + 17'(u1);
    a[1] = rowa + 17'(u2);
    a[2] = rowb + 17'(u2);
    a[3] = rowb + 17'(u1);
    for (int k = 0; k < NTAPS; k++) begin
      tap_d[k]  = a[k][ADDR_W-1:0];
      zero_d[k] = (32'(a[k]) >= TEXELS);
    end
    fu   = pu_q[FRAC_BITS-1:0];
    fv   = pv_q[FRAC_BITS-1:0];
    omfu = ONE - (FRAC_BITS+1)'(fu);
    omfv = ONE - (FRAC_BITS+1)'(fv);
    wgt_d[0] = WGT_W'(omfu) * WGT_W'(omfv);
    wgt_d[1] = WGT_W'(fu) * WGT_W'(omfv);
    wgt_d[2] = WGT_W'(fu) * WGT_W'(fv);
    wgt_d[3] = WGT_W'(omfu) * WGT_W'(fv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else begin
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rw_addr2_q <= addr1_q[ADDR_W-1:0];
    wdata2_q   <= wdata1_q;
    tap_q      <= tap_d;
    zero_q     <= zero_d;
    wgt_q      <= wgt_d;
  end

  assign ctl_o      = ctl2_q;
  assign rw_addr_o  = rw_addr2_q;
  assign wdata_o    = wdata2_q;
  assign tap_addr_o = tap_q;
  assign tap_zero_o = zero_q;
  assign wgt_o      = wgt_q;

endmodule

// ----- design/bwts_blend.sv -----
// ----------------------------------------------------------------------------
// bwts_blend: bilinear blend
// Registered per-channel weighted products, then a four-way sum truncated.
// ----------------------------------------------------------------------------
module bwts_blend (
  input  logic                                    clk_i,
  input  bwts_pkg::texel_t  [bwts_pkg::NTAPS-1:0] texel_i,
  input  logic              [bwts_pkg::NTAPS-1:0] zero_i,
  input  bwts_pkg::weight_t [bwts_pkg::NTAPS-1:0] wgt_i,
  output bwts_pkg::texel_t                        color_o
);
  import bwts_pkg::*;

  logic [PROD_W-1:0] prod_d [4][NTAPS];
  logic [PROD_W-1:0] prod_q [4][NTAPS];
  logic [SUM_W-1:0]  sum [4];
  logic [7:0]        pix;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < NTAPS; k++) begin
        pix = zero_i[k] ? 8'd0 : texel_i[k][8*c +: 8];
        prod_d[c][k] = PROD_W'(pix) * PROD_W'(wgt_i[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = SUM_W'(prod_q[c][0]) + SUM_W'(prod_q[c][1]) +
               SUM_W'(prod_q[c][2]) + SUM_W'(prod_q[c][3]);
      color_o[8*c +: 8] = sum[c][2*FRAC_BITS +: 8];
    end
  end

endmodule

// ----- design/bilinear_wrap_texture_sampler_top.sv -----
// ----------------------------------------------------------------------------
// bilinear_wrap_texture_sampler_top: texture store with bilinear wrap sampler
// The result strobe is registered after the input stage, both address stages,
// the memory read and the blend products. Throughput: one transaction
// per cycle, set by the four read ports (four copies of the texel memory).
// busy stays low and the receiver cannot stall. Reset clears the valid bits
// and sets both size registers to 256; texel memory is undefined until written.
// ----------------------------------------------------------------------------
module bilinear_wrap_texture_sampler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action_i,
  input  logic [7:0]                    texel_x_i,
  input  logic [7:0]                    texel_y_i,
  input  logic [7:0]                    in_red_i,
  input  logic [7:0]                    in_green_i,
  input  logic [7:0]                    in_blue_i,
  input  logic [7:0]                    in_alpha_i,
  input  logic [bwts_pkg::COORD_W-1:0]  coord_u_i,
  input  logic [bwts_pkg::COORD_W-1:0]  coord_v_i,
  output logic                          strobe_o,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_blue_o,
  output logic [7:0]                    out_alpha_o,
  output logic                          hit_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bwts_pkg::*;

  dim_t tex_width_q, tex_height_q, w_eff, h_eff;
  logic cfg_we;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_we = psel && penable && pwrite && pready;
  assign w_eff  = eff_dim(tex_width_q);
  assign h_eff  = eff_dim(tex_height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= dim_t'(MAX_DIM);
      tex_height_q <= dim_t'(MAX_DIM);
    end else if (cfg_we) begin
      if (paddr[2] == REG_WIDTH) begin
        tex_width_q <= pwdata[DIM_W-1:0];
      end else begin
        tex_height_q <= pwdata[DIM_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(tex_height_q) : 32'(tex_width_q);

  // Input register stage.
  ctl_t               ctl0_q;
  logic [7:0]         x0_q, y0_q;
  logic [COORD_W-1:0] u0_q, v0_q;
  texel_t             wdata0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q <= '{valid: start && !busy, act: action_i, inb: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q     <= texel_x_i;
    y0_q     <= texel_y_i;
    u0_q     <= coord_u_i;
    v0_q     <= coord_v_i;
    wdata0_q <= {in_alpha_i, in_blue_i, in_green_i, in_red_i};
  end

  ctl_t                ctl2;
  addr_t               rw_addr2;
  texel_t              wdata2;
  addr_t   [NTAPS-1:0] tap2;
  logic    [NTAPS-1:0] zero2;
  weight_t [NTAPS-1:0] wgt2;

  bwts_addr u_addr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .w_i        (w_eff),
    .h_i        (h_eff),
    .ctl_i      (ctl0_q),
    .x_i        (x0_q),
    .y_i        (y0_q),
    .u_i        (u0_q),
    .v_i        (v0_q),
    .wdata_i    (wdata0_q),
    .ctl_o      (ctl2),
    .rw_addr_o  (rw_addr2),
    .wdata_o    (wdata2),
    .tap_addr_o (tap2),
    .tap_zero_o (zero2),
    .wgt_o      (wgt2)
  );

  // Memory stage: every copy takes each write, each copy serves one tap.
  logic               mem_we;
  logic               is_sample2;
  texel_t [NTAPS-1:0] rdata3;

  assign mem_we     = ctl2.valid && (ctl2.act == ACT_WRITE) && ctl2.inb;
  assign is_sample2 = (ctl2.act == ACT_SAMPLE);

  for (genvar k = 0; k < NTAPS; k++) begin : g_bank
    bwts_ram u_ram (
      .clk_i   (clk_i),
      .we_i    (mem_we),
      .waddr_i (rw_addr2),
      .wdata_i (wdata2),
      .raddr_i (is_sample2 ? tap2[k] : rw_addr2),
      .rdata_o (rdata3[k])
    );
  end

  ctl_t                ctl3_q, ctl4_q;
  logic    [NTAPS-1:0] zero3_q;
  weight_t [NTAPS-1:0] wgt3_q;
  texel_t              rd4_q;
  texel_t              blend4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else begin
      ctl3_q <= ctl2;
      ctl4_q <= ctl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    zero3_q <= zero2;
    wgt3_q  <= wgt2;
    rd4_q   <= rdata3[0];
  end

  bwts_blend u_blend (
    .clk_i   (clk_i),
    .texel_i (rdata3),
    .zero_i  (zero3_q),
    .wgt_i   (wgt3_q),
    .color_o (blend4)
  );

  // Output stage.
  logic   strobe_q, hit_d, hit_q;
  texel_t color_d, color_q;

  always_comb begin
    color_d = '0;
    hit_d   = 1'b0;
    case (ctl4_q.act)
      ACT_WRITE: begin
        hit_d = ctl4_q.inb;
      end
      ACT_READ: begin
        hit_d   = ctl4_q.inb;
        color_d = ctl4_q.inb ? rd4_q : '0;
      end
      ACT_SAMPLE: begin
        hit_d   = 1'b1;
        color_d = blend4;
      end
      default: begin
        hit_d   = 1'b0;
        color_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= ctl4_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
    hit_q   <= hit_d;
  end

  assign strobe_o    = strobe_q;
  assign out_red_o   = color_q[7:0];
  assign out_green_o = color_q[15:8];
  assign out_blue_o  = color_q[23:16];
  assign out_alpha_o = color_q[31:24];
  assign hit_o       = hit_q;

endmodule

// ----- verif/bilinear_wrap_texture_sampler_top_tb.sv -----
// ----------------------------------------------------------------------------
// bilinear_wrap_texture_sampler_top_tb: self-checking bench for the sampler
// Writes, reads and bilinear samples are driven through the command port
// under several texture sizes and idle patterns. A scoreboard predicts every
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module bilinear_wrap_texture_sampler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bwts_pkg::*;

  localparam logic [1:0]  ACT_UNUSED = 2'd3;
  localparam logic [2:0]  ADDR_WIDTH = 3'd0;
  localparam logic [2:0]  ADDR_HEIGHT = 3'd4;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       hit;
  } pixel_res_t;

  class texel_scoreboard;
    bit [31:0]    texels[TEXELS];
    bit           written[TEXELS];
    bit [8:0]     width_reg = 9'd256;
    bit [8:0]     height_reg = 9'd256;
    pixel_res_t   pending[$];
    int unsigned  mismatches = 0;
    int unsigned  n_write = 0, n_read = 0, n_sample = 0, n_other = 0;

    function int unsigned size_in_use(input bit [8:0] r);
      if (r == 0) return 1;
      if (r > MAX_DIM) return MAX_DIM;
      return 32'(r);
    endfunction

    function longint unsigned abs_coord(input logic [23:0] c);
      if (c[23]) return longint'(25'h1000000) - longint'(c);
      return longint'(c);
    endfunction

    // Four neighbour addresses plus the fractional parts of a sample.
    function void sample_taps(input logic [23:0] u, input logic [23:0] v,
                              output int unsigned addr[4],
                              output longint unsigned fu,
                              output longint unsigned fv);
      longint unsigned su, sv, iu, iv, u1, u2, v1, v2, w, h;
      w = size_in_use(width_reg);
      h = size_in_use(height_reg);
      su = abs_coord(u) * w;
      sv = abs_coord(v) * h;
      iu = su >> FRAC_BITS;
      iv = sv >> FRAC_BITS;
      fu = su & 64'hFFFF;
      fv = sv & 64'hFFFF;
      u1 = iu % w;
      u2 = (iu + 1) % w;
      v1 = iv % h;
      v2 = (iv + 1) % h;
      addr[0] = 32'(v1 * w + u1);
      addr[1] = 32'(v1 * w + u2);
      addr[2] = 32'(v2 * w + u2);
      addr[3] = 32'(v2 * w + u1);
    endfunction

    function void note(input logic [1:0] act, input logic [7:0] x, input logic [7:0] y,
                       input logic [31:0] color, input logic [23:0] u,
                       input logic [23:0] v);
      pixel_res_t       res;
      int unsigned      w, h, addr, taps[4];
      longint unsigned  fu, fv, one, wt[4], acc;
      logic [31:0]      t;
      res = '0;
      w = size_in_use(width_reg);
      h = size_in_use(height_reg);
      addr = y * w + x;
      one = 64'd1 << FRAC_BITS;
      if (act == ACT_WRITE || act == ACT_READ) begin
        if (act == ACT_WRITE) n_write++;
        else n_read++;
        if (x < w && y < h && addr < TEXELS) begin
          res.hit = 1'b1;
          if (act == ACT_WRITE) begin
            texels[addr] = color;
            written[addr] = 1'b1;
          end else begin
            t = texels[addr];
            {res.alpha, res.blue, res.green, res.red} = t;
          end
        end
      end else if (act == ACT_SAMPLE) begin
        n_sample++;
        sample_taps(u, v, taps, fu, fv);
        wt[0] = (one - fu) * (one - fv);
        wt[1] = fu * (one - fv);
        wt[2] = fu * fv;
        wt[3] = (one - fu) * fv;
        for (int k = 0; k < 4; k++) begin
          acc = 0;
          for (int n = 0; n < 4; n++) begin
            t = (taps[n] < TEXELS) ? texels[taps[n]] : 32'd0;
            acc += longint'((t >> (8 * k)) & 32'hFF) * wt[n];
          end
          case (k)
            0: res.red = 8'(acc >> (2 * FRAC_BITS));
            1: res.green = 8'(acc >> (2 * FRAC_BITS));
            2: res.blue = 8'(acc >> (2 * FRAC_BITS));
            default: res.alpha = 8'(acc >> (2 * FRAC_BITS));
          endcase
        end
        res.hit = 1'b1;
      end else begin
        n_other++;
      end
      pending.push_back(res);
    endfunction

    function void check(input pixel_res_t got);
      pixel_res_t exp_res;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with none pending: %p", got);
        return;
      end
      exp_res = pending.pop_front();
      if (got !== exp_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected r%0d g%0d b%0d a%0d hit%0b, got r%0d g%0d b%0d a%0d hit%0b",
                   exp_res.red, exp_res.green, exp_res.blue, exp_res.alpha, exp_res.hit,
                   got.red, got.green, got.blue, got.alpha, got.hit);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni, start, busy;
  logic [1:0]  action_i;
  logic [7:0]  texel_x_i, texel_y_i, in_red_i, in_green_i, in_blue_i, in_alpha_i;
  logic [23:0] coord_u_i, coord_v_i;
  logic        strobe_o, hit_o;
  logic [7:0]  out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  texel_scoreboard sb;
  int unsigned     cycles = 0;
  int unsigned     idle_pct = 0;
  int unsigned     n_sent = 0;

  bilinear_wrap_texture_sampler_top u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Accepted transactions feed the predictor; strobed results are checked.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      sb.note(action_i, texel_x_i, texel_y_i,
              {in_alpha_i, in_blue_i, in_green_i, in_red_i}, coord_u_i, coord_v_i);
    if (rst_ni && strobe_o)
      sb.check({out_red_o, out_green_o, out_blue_o, out_alpha_o, hit_o});
  end

  task automatic send(input logic [1:0] act, input logic [7:0] x, input logic [7:0] y,
                      input logic [31:0] color, input logic [23:0] u, input logic [23:0] v);
    n_sent++;
    start <= 1'b1;
    action_i <= act;
    texel_x_i <= x;
    texel_y_i <= y;
    {in_alpha_i, in_blue_i, in_green_i, in_red_i} <= color;
    coord_u_i <= u;
    coord_v_i <= v;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [8:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= {$urandom} << 9 | 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_WIDTH) sb.width_reg = value;
    else sb.height_reg = value;
  endtask

  task automatic write_at(input int unsigned addr);
    int unsigned w;
    w = sb.size_in_use(sb.width_reg);
    send(ACT_WRITE, 8'(addr % w), 8'(addr / w), $urandom, 24'($urandom), 24'($urandom));
  endtask

  // Reads and samples only ever touch texels that hold a written value.
  task automatic read_safe(input logic [7:0] x, input logic [7:0] y);
    int unsigned w, h;
    w = sb.size_in_use(sb.width_reg);
    h = sb.size_in_use(sb.height_reg);
    if (x < w && y < h && !sb.written[y * w + x]) write_at(y * w + x);
    send(ACT_READ, x, y, $urandom, 24'($urandom), 24'($urandom));
  endtask

  task automatic sample_safe(input logic [23:0] u, input logic [23:0] v);
    int unsigned     taps[4];
    longint unsigned fu, fv;
    sb.sample_taps(u, v, taps, fu, fv);
    for (int n = 0; n < 4; n++)
      if (!sb.written[taps[n]]) write_at(taps[n]);
    send(ACT_SAMPLE, 8'($urandom), 8'($urandom), $urandom, u, v);
  endtask

  // The count covers every transaction sent, including the priming writes.
  task automatic random_items(input int unsigned count);
    int unsigned w, h, pick, base;
    w = sb.size_in_use(sb.width_reg);
    h = sb.size_in_use(sb.height_reg);
    base = n_sent;
    while (n_sent - base < count) begin
      pick = $urandom_range(99);
      if (pick < 30)
        send(ACT_WRITE, 8'($urandom_range(w - 1)), 8'($urandom_range(h - 1)), $urandom,
             24'($urandom), 24'($urandom));
      else if (pick < 36)
        send(ACT_WRITE, 8'($urandom), 8'($urandom), $urandom, 24'($urandom),
             24'($urandom));
      else if (pick < 56)
        read_safe(8'($urandom_range(w - 1)), 8'($urandom_range(h - 1)));
      else if (pick < 61)
        read_safe(8'($urandom), 8'($urandom));
      else if (pick < 96)
        sample_safe(24'($urandom), 24'($urandom));
      else
        send(ACT_UNUSED, 8'($urandom), 8'($urandom), $urandom, 24'($urandom),
             24'($urandom));
    end
  endtask

  initial begin
    int unsigned widths[10]  = '{256, 1, 0, 511, 5, 16, 2, 256, 13, 100};
    int unsigned heights[10] = '{256, 1, 0, 300, 3, 16, 256, 2, 7, 37};
    int unsigned idles[4]    = '{0, 47, 0, 31};
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    action_i = ACT_WRITE;
    {texel_x_i, texel_y_i, in_red_i, in_green_i, in_blue_i, in_alpha_i} = '0;
    coord_u_i = '0;
    coord_v_i = '0;
    {psel, penable, pwrite} = '0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corners, full-scale colors, every action, coordinate extremes.
    send(ACT_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF, '0, '0);
    send(ACT_WRITE, 8'd255, 8'd255, 32'h0000_0000, '0, '0);
    send(ACT_WRITE, 8'd255, 8'd0, 32'h8040_20FF, '0, '0);
    send(ACT_WRITE, 8'd0, 8'd255, 32'h0102_0408, '0, '0);
    read_safe(8'd0, 8'd0);
    read_safe(8'd255, 8'd255);
    read_safe(8'd255, 8'd0);
    send(ACT_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    sample_safe(24'h00_0000, 24'h00_0000);
    sample_safe(24'h80_0000, 24'h80_0000);
    sample_safe(24'h7F_FFFF, 24'h80_0001);
    sample_safe(24'hFF_FFFF, 24'h00_8000);
    drain();
    write_reg(ADDR_WIDTH, 9'd5);
    write_reg(ADDR_HEIGHT, 9'd3);
    send(ACT_WRITE, 8'd5, 8'd0, 32'h1234_5678, '0, '0);
    send(ACT_WRITE, 8'd0, 8'd3, 32'h1234_5678, '0, '0);
    send(ACT_WRITE, 8'd4, 8'd2, 32'hA5A5_5A5A, '0, '0);
    read_safe(8'd4, 8'd2);
    read_safe(8'd255, 8'd255);
    sample_safe(24'h00_FFFF, 24'h01_0000);
    sample_safe(24'h80_0000, 24'h7F_0000);
    drain();

    for (int p = 0; p < 10; p++) begin
      write_reg(ADDR_WIDTH, 9'(widths[p]));
      write_reg(ADDR_HEIGHT, 9'(heights[p]));
      idle_pct = idles[p % 4];
      random_items(70);
      if (p == 4) drain();
      random_items(70);
      drain();
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    $display("Covered %0d writes, %0d reads, %0d samples, %0d unused actions",
             sb.n_write, sb.n_read, sb.n_sample, sb.n_other);
    $display("over ten texture sizes including 1x1, 256x256 and out-of-range registers");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
